// ===== rtl/bmm_pkg.sv =====
// Shared types and constants for the Blakley modular multiplier.
`timescale 1ns / 1ps

package bmm_pkg;

  // Width of every operand, modulus and result field
  localparam int unsigned FieldW = 16;

  // Default number of multiplier bit positions scanned
  localparam int unsigned OperandBitsDef = 16;

  // Modulus after reset
  localparam logic [FieldW-1:0] ModulusReset = 16'd143;

  // Input item
  typedef struct packed {
    logic [FieldW-1:0] multiplicand;
    logic [FieldW-1:0] multiplier;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [FieldW-1:0] product_mod;
    logic              modulus_error;
  } out_item_t;

  // Payload of the multiplicand reduction stages
  typedef struct packed {
    logic [FieldW-1:0] rem;
    logic [FieldW-1:0] x;
    logic [FieldW-1:0] y;
  } xred_t;

  // Payload of the multiplier scan stages
  typedef struct packed {
    logic [FieldW-1:0] acc;
    logic [FieldW-1:0] xr;
    logic [FieldW-1:0] y;
  } scan_t;

endpackage

// ===== rtl/blakley_modular_multiplier.sv =====
// Top level of the pipelined Blakley modular multiplier.
`timescale 1ns / 1ps

// Computes multiplicand * multiplier mod m, where m is the single
// configuration register (reset value 143). One operand pair is taken per
// cycle and one result leaves per cycle while the output is not stalled.
// The first 16 stages reduce the multiplicand modulo m one dividend bit at a
// time (restoring division); the next OPERAND_BITS stages scan the
// multiplier most significant bit first, each doubling the partial
// remainder, adding the reduced multiplicand when the bit is set and
// bringing the sum back below m with at most one subtraction of m or 2m.
// Every stage holds its own valid bit and only backs up when the stage after
// it is full and blocked, so bubbles collapse and a stalled output does not
// stop the input while empty stages remain. A zero modulus gives a product
// of 0 with modulus_error set. The modulus may only be rewritten while no
// transfer is in flight; the config channel is always ready.

module blakley_modular_multiplier #(
  parameter int unsigned OPERAND_BITS = bmm_pkg::OperandBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bmm_pkg::FieldW-1:0]  cfg_data_i,
  // operand channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  bmm_pkg::in_item_t           in_data_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output bmm_pkg::out_item_t          out_data_o
);

  localparam int unsigned NumXred = bmm_pkg::FieldW;

  logic [bmm_pkg::FieldW-1:0] modulus_d, modulus_q;
  logic                       mod_zero;

  // reduction chain: index k feeds stage k
  logic           xv   [0:NumXred];
  logic           xrdy [0:NumXred];
  bmm_pkg::xred_t xd   [0:NumXred];

  // scan chain
  logic           sv   [0:OPERAND_BITS];
  logic           srdy [0:OPERAND_BITS];
  bmm_pkg::scan_t sd   [0:OPERAND_BITS];

  // ---- modulus register
  assign cfg_ready_o = 1'b1;
  assign modulus_d   = cfg_valid_i ? cfg_data_i : modulus_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= bmm_pkg::ModulusReset;
    end else begin
      modulus_q <= modulus_d;
    end
  end

  assign mod_zero = (modulus_q == '0);

  // ---- input side
  assign xv[0]      = in_valid_i;
  assign xd[0].rem  = '0;
  assign xd[0].x    = in_data_i.multiplicand;
  assign xd[0].y    = in_data_i.multiplier;
  assign in_stall_o = !xrdy[0];

  // ---- x mod m, MSB first
  for (genvar k = 0; k < NumXred; k++) begin : g_xred
    bmm_xred_stage #(
      .BitPos(NumXred - 1 - k)
    ) u_stage (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .modulus_i (modulus_q),
      .valid_i   (xv[k]),
      .ready_o   (xrdy[k]),
      .data_i    (xd[k]),
      .valid_o   (xv[k+1]),
      .ready_i   (xrdy[k+1]),
      .data_o    (xd[k+1])
    );
  end

  // ---- hand over to the scan chain
  assign sv[0]         = xv[NumXred];
  assign xrdy[NumXred] = srdy[0];
  assign sd[0].acc     = '0;
  assign sd[0].xr      = xd[NumXred].rem;
  assign sd[0].y       = xd[NumXred].y;

  for (genvar i = 0; i < OPERAND_BITS; i++) begin : g_scan
    bmm_scan_stage #(
      .BitPos(OPERAND_BITS - 1 - i)
    ) u_stage (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .modulus_i (modulus_q),
      .valid_i   (sv[i]),
      .ready_o   (srdy[i]),
      .data_i    (sd[i]),
      .valid_o   (sv[i+1]),
      .ready_i   (srdy[i+1]),
      .data_o    (sd[i+1])
    );
  end

  // ---- output side: last scan stage is the output register
  assign srdy[OPERAND_BITS]       = !out_stall_i;
  assign out_valid_o              = sv[OPERAND_BITS];
  assign out_data_o.product_mod   = mod_zero ? '0 : sd[OPERAND_BITS].acc;
  assign out_data_o.modulus_error = mod_zero;

`ifndef SYNTHESIS
  // a delivered product is fully reduced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !mod_zero |-> out_data_o.product_mod < modulus_q)
    else $error("product not reduced below modulus");

  // reduced multiplicand leaving the division chain is below m
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    xv[NumXred] && !mod_zero |-> xd[NumXred].rem < modulus_q)
    else $error("multiplicand reduction out of range");

  // the input only backs up once the pipe is full behind a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_stall_i && out_valid_o)
    else $error("input stalled without output back-pressure");
`endif

endmodule

// ===== rtl/bmm_xred_stage.sv =====
// One restoring-division step of the multiplicand reduction x mod m.
`timescale 1ns / 1ps

module bmm_xred_stage #(
  parameter int unsigned BitPos = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [bmm_pkg::FieldW-1:0]  modulus_i,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  bmm_pkg::xred_t              data_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output bmm_pkg::xred_t              data_o
);

  logic                       valid_d, valid_q;
  bmm_pkg::xred_t             data_d, data_q;
  logic [bmm_pkg::FieldW:0]   shifted;
  logic [bmm_pkg::FieldW:0]   diff;

  // bring down the next dividend bit, subtract the modulus if it fits
  always_comb begin
    shifted = {data_i.rem, data_i.x[BitPos]};
    diff    = shifted - {1'b0, modulus_i};
    data_d  = data_i;
    if (shifted >= {1'b0, modulus_i}) begin
      data_d.rem = diff[bmm_pkg::FieldW-1:0];
    end else begin
      data_d.rem = shifted[bmm_pkg::FieldW-1:0];
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/bmm_scan_stage.sv =====
// One Blakley step: acc = (2*acc + bit*xr) mod m.
`timescale 1ns / 1ps

module bmm_scan_stage #(
  parameter int unsigned BitPos = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [bmm_pkg::FieldW-1:0]  modulus_i,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  bmm_pkg::scan_t              data_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output bmm_pkg::scan_t              data_o
);

  logic                         valid_d, valid_q;
  bmm_pkg::scan_t               data_d, data_q;
  logic                         scan_bit;
  logic [bmm_pkg::FieldW+1:0]   sum;
  logic [bmm_pkg::FieldW+1:0]   mod1;
  logic [bmm_pkg::FieldW+1:0]   mod2;

  // positions beyond the operand field read as zero
  if (BitPos < bmm_pkg::FieldW) begin : g_bit
    assign scan_bit = data_i.y[BitPos];
  end else begin : g_zero
    assign scan_bit = 1'b0;
  end

  // acc and xr are below m, so the sum stays below 3m
  always_comb begin
    mod1   = {2'b00, modulus_i};
    mod2   = {1'b0, modulus_i, 1'b0};
    sum    = {1'b0, data_i.acc, 1'b0} + (scan_bit ? {2'b00, data_i.xr} : '0);
    data_d = data_i;
    priority if (sum >= mod2) begin
      data_d.acc = bmm_pkg::FieldW'(sum - mod2);
    end else if (sum >= mod1) begin
      data_d.acc = bmm_pkg::FieldW'(sum - mod1);
    end else begin
      data_d.acc = sum[bmm_pkg::FieldW-1:0];
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== dv/bmm_checker.sv =====
// Result checker for the Blakley modular multiplier: predicts every result and compares it.
`timescale 1ns / 1ps

module bmm_checker #(
  parameter int unsigned OPERAND_BITS = bmm_pkg::OperandBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [bmm_pkg::FieldW-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  bmm_pkg::in_item_t          in_data_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  bmm_pkg::out_item_t         out_data_i,
  output int                         pending_o,
  output int                         fails_o
);

  import bmm_pkg::*;

  // one product still owed by the block, with the operands it came from
  typedef struct {
    in_item_t          op;
    logic [FieldW-1:0] m;
    out_item_t         res;
  } owed_product_t;

  owed_product_t     owed_q[$];
  logic [FieldW-1:0] modulus_q;

  // Interleaved multiply: double, add x on a set bit, reduce, MSB first
  function automatic out_item_t mod_product(in_item_t op, logic [FieldW-1:0] m);
    logic [31:0] r;
    out_item_t   res;
    r = '0;
    res.modulus_error = (m == '0);
    if (m != '0) begin
      for (int pos = int'(OPERAND_BITS) - 1; pos >= 0; pos--) begin
        r = r << 1;
        if (pos < int'(FieldW) && op.multiplier[pos]) r = r + op.multiplicand;
        r = r % m;
      end
    end
    res.product_mod = r[FieldW-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    owed_product_t head;
    if (!rst_ni) begin
      modulus_q = ModulusReset;
      owed_q.delete();
      fails_o   = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (owed_q.size() == 0) begin
          if (fails_o < 10)
            $display("unexpected result: product %0d error %0b",
                     out_data_i.product_mod, out_data_i.modulus_error);
          fails_o++;
        end else begin
          head = owed_q.pop_front();
          if (out_data_i.product_mod !== head.res.product_mod ||
              out_data_i.modulus_error !== head.res.modulus_error) begin
            if (fails_o < 10)
              $display("bad result for %0d * %0d mod %0d: want %0d/%0b, got %0d/%0b",
                       head.op.multiplicand, head.op.multiplier, head.m,
                       head.res.product_mod, head.res.modulus_error,
                       out_data_i.product_mod, out_data_i.modulus_error);
            fails_o++;
          end
        end
      end
      // an operand transfer sees the modulus held before this edge
      if (in_valid_i && !in_stall_i)
        owed_q.push_back('{op: in_data_i, m: modulus_q,
                           res: mod_product(in_data_i, modulus_q)});
      if (cfg_valid_i && cfg_ready_i) modulus_q = cfg_data_i;
      pending_o = owed_q.size();
    end
  end

endmodule

// ===== dv/tb_blakley_modular_multiplier.sv =====
// Testbench top for the Blakley modular multiplier: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module tb_blakley_modular_multiplier;

  import bmm_pkg::*;

  localparam int unsigned OperandBits = OperandBitsDef;
  // pipeline depth: 16 multiplicand reduction stages plus one per scanned bit
  localparam int          Latency     = 16 + OperandBits;
  localparam int          ItemTarget  = 1200;
  localparam int          CycleLimit  = 400000;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [FieldW-1:0] cfg_data  = '0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;

  int                pending;
  int                fails;
  int                n_sent      = 0;
  int                cycles      = 0;
  int                tx_idle_pct = 13;
  int                rx_idle_pct = 51;
  logic [FieldW-1:0] cur_mod     = ModulusReset;

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  blakley_modular_multiplier #(
    .OPERAND_BITS (OperandBits)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  bmm_checker #(
    .OPERAND_BITS (OperandBits)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .pending_o   (pending),
    .fails_o     (fails)
  );

  // Result side back-pressure, redrawn every cycle at the falling edge
  always @(negedge clk_i) begin
    out_stall = rst_ni && (rx_idle_pct != 0) && ($urandom_range(99) < rx_idle_pct);
  end

  // Watchdog: a hung handshake ends the run as a failure
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("blakley_modular_multiplier: mismatch");
      $finish;
    end
  end

  // Idling profile follows progress: sender light / receiver heavy, then the
  // reverse, then a flat-out stretch with no idling on either side.
  function automatic void set_idling();
    if (n_sent < ItemTarget / 3) begin
      tx_idle_pct = 13;
      rx_idle_pct = 51;
    end else if (n_sent < 2 * ItemTarget / 3) begin
      tx_idle_pct = 51;
      rx_idle_pct = 13;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  endfunction

  // Drop valid and hold off until every owed product has come out
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // One operand transfer; valid stays up across back-to-back items, and
  // in_stall is read at the rising edge before the block updates it
  task automatic send_operands(input logic [FieldW-1:0] x, input logic [FieldW-1:0] y);
    set_idling();
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data  = '{multiplicand: x, multiplier: y};
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
    n_sent++;
  endtask

  // Modulus only changes with the pipe empty
  task automatic write_modulus(input logic [FieldW-1:0] m);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_data  = m;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid = 1'b0;
    cur_mod   = m;
  endtask

  // Operand mix: corners, tiny values, values round the modulus, full random
  function automatic logic [FieldW-1:0] pick_operand();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return FieldW'($urandom_range(0, 15));
      3:       return cur_mod - FieldW'($urandom_range(0, 2));
      4:       return cur_mod + FieldW'($urandom_range(0, 2));
      default: return FieldW'($urandom);
    endcase
  endfunction

  initial begin
    int                seg_len;
    logic [FieldW-1:0] m;

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset modulus 143 with operand extremes and bit patterns
    send_operands(16'h0000, 16'h0000);
    send_operands(16'hFFFF, 16'hFFFF);
    send_operands(16'hFFFF, 16'h0000);
    send_operands(16'h0000, 16'hFFFF);
    send_operands(16'd1, 16'd1);
    send_operands(16'd142, 16'd142);
    send_operands(16'd143, 16'd1);
    send_operands(16'd1, 16'h8000);
    send_operands(16'h8000, 16'h8000);
    send_operands(16'hAAAA, 16'h5555);
    send_operands(16'h5555, 16'hAAAA);
    send_operands(16'd144, 16'd2);
    send_operands(16'hFFFF, 16'd1);

    // zero modulus: error flag, product 0
    write_modulus(16'd0);
    send_operands(16'hFFFF, 16'hFFFF);
    send_operands(16'd1234, 16'd5678);

    // modulus of one: everything collapses to 0
    write_modulus(16'd1);
    send_operands(16'hFFFF, 16'hFFFF);
    send_operands(16'd7, 16'd9);

    // largest modulus
    write_modulus(16'hFFFF);
    send_operands(16'hFFFF, 16'hFFFF);
    send_operands(16'hFFFE, 16'd2);
    send_operands(16'h8000, 16'd2);

    // Random: segments under varied moduli, occasional full drain mid-segment
    while (n_sent < ItemTarget) begin
      case ($urandom_range(0, 9))
        0:       m = '0;
        1:       m = 16'd1;
        2:       m = '1;
        3:       m = FieldW'($urandom_range(2, 64));
        4:       m = 16'h8000 | FieldW'($urandom_range(0, 1));
        default: m = FieldW'($urandom_range(1, 65535));
      endcase
      write_modulus(m);
      seg_len = (m <= 1) ? $urandom_range(10, 30) : $urandom_range(30, 150);
      repeat (seg_len) begin
        send_operands(pick_operand(), pick_operand());
        if ($urandom_range(0, 99) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (2 * Latency) @(negedge clk_i);

    if (fails == 0 && pending == 0) begin
      $display("blakley_modular_multiplier: match");
    end else begin
      $display("blakley_modular_multiplier: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bmm_pkg.sv
rtl/bmm_xred_stage.sv
rtl/bmm_scan_stage.sv
rtl/blakley_modular_multiplier.sv
dv/bmm_checker.sv
dv/tb_blakley_modular_multiplier.sv
